// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/bmhq_ram.sv =====
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue.
// Input words: in_tuser is the command (insert or remove minimum), in_tdata
// carries the key for an insert. Every input word yields exactly one output
// word: min key after the operation, removed key, key count, and a status
// in out_tuser (ok, insert dropped because full, remove on empty).
// Keys live in a single-port-write, registered-read RAM; the root is mirrored
// in a register so the minimum is reported without an extra read.
// One word is processed at a time; the next is accepted only after the
// previous result is registered and the block is back in idle. For each
// heap level the key moves through (at most log2(CAPACITY)), the block does
// one RAM read per compared key, then a compare-and-write step.
// in_tready is high while the block is idle. The output register holds a
// finished result until out_tready; while it is still occupied, the next
// item is accepted and worked on, and only its final hand-off waits.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// output word; RAM contents are not cleared and need not be.
module binary_min_heap_queue #(
  parameter int CAPACITY  = bmhq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((KEY_WIDTH+7)/8)*8-1:0] in_tdata,   // key
  input  logic in_tuser,                              // cmd
  output logic out_tvalid,
  input  logic out_tready,
  // min_key, removed_key, count
  output logic [((2*KEY_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] out_tdata,
  output logic [1:0] out_tuser                        // status
);

  import bmhq_pkg::*;

  localparam int KW  = KEY_WIDTH;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = $clog2(CAPACITY);
  localparam int OW  = 2 * KW + CW;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_P = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_CHK, S_UP_CMP, S_DN_LAST, S_DN_CHK, S_DN_L, S_DN_R, S_FIN
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   pos_r;
  logic [KW-1:0]   x_r;
  logic [KW-1:0]   lkey_r;
  logic [KW-1:0]   root_r;
  logic [KW-1:0]   rem_r;
  status_t         stat_r;

  logic            out_valid_r;
  logic [KW-1:0]   out_min_r;
  logic [KW-1:0]   out_rem_r;
  logic [CW-1:0]   out_cnt_r;
  status_t         out_stat_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [KW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [KW-1:0]   ram_rdata;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   pos_m1;
  logic [CW-1:0]   par;
  logic [CW-1:0]   par_m1;
  logic [CW:0]     child;
  logic [CW:0]     child_m1;
  logic            has_r;
  logic            right_sel;
  logic [KW-1:0]   cand;
  logic            cand_lt;
  logic            accept;
  logic            out_free;

  bmhq_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1    = cnt_r - ONE_P;
  assign pos_m1    = pos_r - ONE_P;
  assign par       = pos_r >> 1;
  assign par_m1    = par - ONE_P;
  assign child     = {pos_r, 1'b0};
  assign child_m1  = child - (CW+1)'(1);
  assign has_r     = child < {1'b0, cnt_r};
  assign right_sel = (state_r == S_DN_R) && (ram_rdata < lkey_r);
  assign cand      = (state_r == S_DN_R) ? (right_sel ? ram_rdata : lkey_r) : ram_rdata;
  assign cand_lt   = cand < x_r;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;

  always_comb begin
    out_tdata         = '0;
    out_tdata[OW-1:0] = {out_cnt_r, out_rem_r, out_min_r};
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_m1[AW-1:0];
    ram_wdata = x_r;
    ram_raddr = cnt_m1[AW-1:0];
    unique case (state_r)
      S_UP_CHK: begin
        ram_raddr = par_m1[AW-1:0];
        if (pos_r == ONE_P) begin
          ram_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (x_r < ram_rdata) begin
          ram_wdata = ram_rdata;
        end
      end
      S_DN_CHK: begin
        ram_raddr = child_m1[AW-1:0];
        if (child > {1'b0, cnt_r}) begin
          ram_we = 1'b1;
        end
      end
      S_DN_L: begin
        ram_raddr = child[AW-1:0];
        if (!has_r) begin
          ram_we = 1'b1;
          if (cand_lt) begin
            ram_wdata = cand;
          end
        end
      end
      S_DN_R: begin
        ram_we = 1'b1;
        if (cand_lt) begin
          ram_wdata = cand;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we && ram_waddr == '0) begin
      root_r <= ram_wdata;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_tuser == CMD_INSERT) begin
              rem_r <= '0;
              if (cnt_r == CAP_C) begin
                stat_r  <= ST_FULL;
                state_r <= S_FIN;
              end else begin
                stat_r  <= ST_OK;
                cnt_r   <= cnt_r + ONE_P;
                pos_r   <= cnt_r + ONE_P;
                x_r     <= in_tdata[KW-1:0];
                state_r <= S_UP_CHK;
              end
            end else begin
              if (cnt_r == '0) begin
                rem_r   <= '0;
                stat_r  <= ST_EMPTY;
                state_r <= S_FIN;
              end else begin
                rem_r  <= root_r;
                stat_r <= ST_OK;
                cnt_r  <= cnt_m1;
                pos_r  <= ONE_P;
                if (cnt_r == ONE_P) begin
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_DN_LAST;
                end
              end
            end
          end
        end
        S_UP_CHK: begin
          if (pos_r == ONE_P) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (x_r < ram_rdata) begin
            pos_r   <= par;
            state_r <= S_UP_CHK;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DN_LAST: begin
          x_r     <= ram_rdata;
          state_r <= S_DN_CHK;
        end
        S_DN_CHK: begin
          if (child > {1'b0, cnt_r}) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_DN_L;
          end
        end
        S_DN_L: begin
          lkey_r <= ram_rdata;
          if (has_r) begin
            state_r <= S_DN_R;
          end else if (cand_lt) begin
            pos_r   <= child[CW-1:0];
            state_r <= S_DN_CHK;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DN_R: begin
          if (cand_lt) begin
            pos_r   <= right_sel ? (child[CW-1:0] + ONE_P) : child[CW-1:0];
            state_r <= S_DN_CHK;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_min_r   <= (cnt_r != '0) ? root_r : '0;
            out_rem_r   <= rem_r;
            out_cnt_r   <= cnt_r;
            out_stat_r  <= stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/tb_binary_min_heap_queue.sv =====
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int KW          = KEY_WIDTH_DEF;
  localparam int CNTW        = $clog2(CAP + 1);
  localparam int IN_W        = ((KW + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * KW + CNTW + 7) / 8) * 8;
  localparam int RAND_WORDS  = 750;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 80;

  typedef struct {
    logic          cmd;
    logic [KW-1:0] key;
  } heap_op_t;

  typedef struct {
    logic [KW-1:0]   min_key;
    logic [KW-1:0]   removed_key;
    logic [CNTW-1:0] count;
    status_t         status;
  } heap_rsp_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tuser   = CMD_INSERT;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;

  binary_min_heap_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  heap_op_t  op_queue[$];
  heap_rsp_t rsp_queue[$];

  // Shadow heap, one-based
  logic [KW-1:0] shadow_keys[1:CAP];
  int            shadow_count = 0;

  int words_sent    = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int hold_left     = 0;
  bit hold_done     = 0;
  int stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void shadow_swap(int a, int b);
    logic [KW-1:0] t;
    t              = shadow_keys[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_keys[b] = t;
  endfunction

  function automatic heap_rsp_t heap_apply(logic cmd, logic [KW-1:0] key);
    heap_rsp_t r;
    int        p;
    int        c;
    r.removed_key = '0;
    r.status      = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        shadow_count++;
        shadow_keys[shadow_count] = key;
        p = shadow_count;
        while (p > 1 && shadow_keys[p] < shadow_keys[p / 2]) begin
          shadow_swap(p, p / 2);
          p = p / 2;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_key = shadow_keys[1];
        if (shadow_count == 1) begin
          shadow_count = 0;
        end else begin
          shadow_swap(1, shadow_count);
          shadow_count--;
          p = 1;
          while (2 * p <= shadow_count) begin
            c = 2 * p;
            if (c + 1 <= shadow_count && shadow_keys[c + 1] < shadow_keys[c])
              c = c + 1;
            if (!(shadow_keys[c] < shadow_keys[p]))
              break;
            shadow_swap(p, c);
            p = c;
          end
        end
      end
    end
    r.min_key = (shadow_count != 0) ? shadow_keys[1] : '0;
    r.count   = CNTW'(shadow_count);
    return r;
  endfunction

  function automatic logic [KW-1:0] pick_key(int style);
    case (style)
      0: return KW'($urandom);
      1: return KW'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KW-1){1'b0}}};
          default: return {1'b0, {(KW-1){1'b1}}};
        endcase
      end
      default: return KW'($urandom_range(1000, 1100));
    endcase
  endfunction

  function automatic void push_op(logic cmd, logic [KW-1:0] key);
    heap_op_t op;
    op.cmd   = cmd;
    op.key   = key;
    op_queue = {op_queue, op};
  endfunction

  // driver
  always @(posedge clk) begin
    heap_op_t  op;
    heap_rsp_t rsp;
    bit        quiet;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rsp       = heap_apply(in_tuser, in_tdata[KW-1:0]);
        rsp_queue = {rsp_queue, rsp};
        words_sent++;
      end
      if (!in_tvalid || in_tready) begin
        quiet = (words_sent >= 300 && words_sent < 420);
        if (op_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 19)) begin
          op = op_queue.pop_front();
          in_tuser  <= op.cmd;
          in_tdata  <= IN_W'(op.key);
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_rsp_t exp_rsp;
    heap_rsp_t got;
    bit        quiet;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.min_key     = out_tdata[KW-1:0];
        got.removed_key = out_tdata[2*KW-1:KW];
        got.count       = out_tdata[2*KW+CNTW-1:2*KW];
        got.status      = status_t'(out_tuser);
        if (rsp_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected output word min=%h rem=%h cnt=%0d st=%0d",
                     got.min_key, got.removed_key, got.count, got.status);
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (got.min_key !== exp_rsp.min_key || got.removed_key !== exp_rsp.removed_key ||
              got.count !== exp_rsp.count || got.status !== exp_rsp.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: word %0d exp %h %h %0d %0d, got %h %h %0d %0d",
                       words_checked, exp_rsp.min_key, exp_rsp.removed_key, exp_rsp.count,
                       exp_rsp.status, got.min_key, got.removed_key, got.count, got.status);
          end
        end
        words_checked++;
      end
      quiet = (words_checked >= 300 && words_checked < 420);
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && words_checked >= 120) begin
        // long back-pressure so the output register stays occupied and the block stalls its input
        hold_done  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int kind;
    int len;
    int style;
    int pct;

    // directed: empty remove, extremes, duplicates, single-key remove
    push_op(CMD_REMOVE, pick_key(0));
    push_op(CMD_INSERT, '0);
    push_op(CMD_INSERT, '1);
    push_op(CMD_REMOVE, '1);
    push_op(CMD_REMOVE, '0);
    push_op(CMD_REMOVE, pick_key(0));
    push_op(CMD_INSERT, KW'(5));
    push_op(CMD_INSERT, KW'(5));
    push_op(CMD_INSERT, KW'(3));
    push_op(CMD_INSERT, '1);
    push_op(CMD_INSERT, {1'b1, {(KW-1){1'b0}}});
    push_op(CMD_INSERT, KW'(1));
    push_op(CMD_REMOVE, pick_key(0));
    push_op(CMD_REMOVE, pick_key(0));
    push_op(CMD_REMOVE, pick_key(0));
    push_op(CMD_INSERT, {1'b0, {(KW-1){1'b1}}});
    for (int i = 0; i < 5; i++)
      push_op(CMD_REMOVE, pick_key(0));

    // fill past capacity, then drain past empty
    n = op_queue.size();
    style = $urandom_range(0, 3);
    for (int i = 0; i < CAP + 6; i++) begin
      push_op(CMD_INSERT, pick_key(style));
      n++;
    end
    for (int i = 0; i < CAP + 4; i++) begin
      push_op(CMD_REMOVE, pick_key(0));
      n++;
    end

    while (n < RAND_WORDS) begin
      kind  = $urandom_range(0, 3);
      style = $urandom_range(0, 3);
      case (kind)
        0: begin len = $urandom_range(20, 60); pct = 50; end
        1: begin len = $urandom_range(40, 90); pct = 85; end
        2: begin len = $urandom_range(40, 90); pct = 15; end
        default: begin len = $urandom_range(5, 15); pct = 50; style = 0; end
      endcase
      if (len > RAND_WORDS - n)
        len = RAND_WORDS - n;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < pct)
          push_op(CMD_INSERT, pick_key(style));
        else
          push_op(CMD_REMOVE, pick_key(0));
        n++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || in_tvalid)
      @(posedge clk);
    while (rsp_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
